/* design/rws_pkg.sv */
// Package with the shared constants, types and codes of the retransmit window scheduler.
package rws_pkg;

  localparam int unsigned SLOTS_DEFAULT = 8;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [31:0] MAX_TICKS = 32'hFFFF_FFFF;

  localparam logic [3:0]  WSIZE_RESET = 4'd8;
  localparam logic [31:0] ITIMEOUT_RESET = 32'd2;
  localparam logic [7:0]  THRESH_RESET = 8'd3;

  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_INIT_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_ACK_THRESH = 2'd2;

  typedef enum logic [1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_ACK = 2'd1,
    KIND_POLL = 2'd2,
    KIND_RESCHED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_REFUSED = 2'd1,
    ST_NOTHING_DUE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_APPLY,
    S_SCAN2,
    S_OUT
  } state_t;

  function automatic logic is_older(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    begin
      d = a - b;
      return d >= HALF_RANGE;
    end
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? MAX_TICKS : s[31:0];
    end
  endfunction

endpackage

/* design/rws_if.sv */
// Valid/ready channel interfaces for commands and results.
interface rws_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now;
  logic [31:0] ack_id;
  logic [4:0]  opcode;
  modport source (output valid, kind, now, ack_id, opcode, input ready);
  modport sink (input valid, kind, now, ack_id, opcode, output ready);
endinterface

interface rws_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  slot;
  logic [31:0] pkt_seq;
  logic [4:0]  sent_opcode;
  logic [31:0] wait_ticks;
  logic        window_empty;
  logic [3:0]  sequenced_free;
  modport source (output valid, status, slot, pkt_seq, sent_opcode, wait_ticks,
                  window_empty, sequenced_free, input ready);
  modport sink (input valid, status, slot, pkt_seq, sent_opcode, wait_ticks,
                window_empty, sequenced_free, output ready);
endinterface

/* design/rws_regs.sv */
// APB configuration registers of the scheduler.
module rws_regs
  import rws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  window_size,
  output logic [31:0] first_timeout,
  output logic [7:0]  ack_threshold
);

  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
      first_timeout <= ITIMEOUT_RESET;
      ack_threshold <= THRESH_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_WINDOW_SIZE: window_size <= pwdata[3:0];
        REG_INIT_TIMEOUT: first_timeout <= pwdata;
        REG_ACK_THRESH: ack_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW_SIZE: prdata = {28'd0, window_size};
      REG_INIT_TIMEOUT: prdata = first_timeout;
      REG_ACK_THRESH: prdata = {24'd0, ack_threshold};
      default: prdata = 32'd0;
    endcase
  end

endmodule

/* design/rws_engine.sv */
// Slot store and the sequencer that visits one slot per cycle.
module rws_engine
  import rws_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  window_size,
  input  logic [31:0] first_timeout,
  input  logic [7:0]  ack_threshold,
  rws_cmd_if.sink     cmd,
  rws_res_if.source   res
);

  localparam int unsigned IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned CW = $clog2(WINDOW_SLOTS + 1);

  state_t state, state_next;

  logic [WINDOW_SLOTS-1:0] slot_active;
  logic [31:0] slot_id [WINDOW_SLOTS];
  logic [4:0]  slot_opcode [WINDOW_SLOTS];
  logic [31:0] slot_next_try [WINDOW_SLOTS];
  logic [31:0] slot_timeout [WINDOW_SLOTS];
  logic [7:0]  slot_ack_count [WINDOW_SLOTS];
  logic [31:0] next_id;

  logic [1:0]  kind_r;
  logic [31:0] now_r, ack_r;
  logic [4:0]  opc_r;
  logic [CW-1:0] size;
  logic [CW-1:0] idx;
  logic [IW-1:0] ix;

  // Per-scan accumulators.
  logic        found;
  logic [31:0] oldest;
  logic        free_found;
  logic [IW-1:0] free_ix;
  logic        best_found;
  logic [IW-1:0] best_ix;
  logic [31:0] best_id;
  logic [31:0] wait_acc;

  logic [1:0]  o_status;
  logic [2:0]  o_slot;
  logic [31:0] o_pid;
  logic [4:0]  o_sop;

  logic last;
  logic act;
  logic due;

  always_comb begin
    if (window_size == 4'd0) size = CW'(1);
    else if (32'(window_size) > WINDOW_SLOTS) size = CW'(WINDOW_SLOTS);
    else size = CW'(window_size);
  end

  assign ix = idx[IW-1:0];
  assign last = (idx == size - CW'(1));
  assign act = slot_active[ix];
  assign due = (slot_ack_count[ix] >= ack_threshold) || (now_r >= slot_next_try[ix]);

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.valid) state_next = S_SCAN1;
      S_SCAN1: if (last) state_next = S_APPLY;
      S_APPLY: if (kind_r == KIND_POLL || kind_r == KIND_ENQUEUE) state_next = S_SCAN2;
               else if (last) state_next = S_SCAN2;
      S_SCAN2: if (last) state_next = S_OUT;
      S_OUT: if (res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      next_id <= 32'd0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          kind_r <= cmd.kind;
          now_r <= cmd.now;
          ack_r <= cmd.ack_id;
          opc_r <= cmd.opcode;
          found <= 1'b0;
          free_found <= 1'b0;
          best_found <= 1'b0;
          free_ix <= '0;
          best_ix <= '0;
          best_id <= 32'd0;
        end
        S_SCAN1: begin
          // Oldest ID, first free slot and oldest due slot in one pass.
          if (act && (!found || is_older(slot_id[ix], oldest))) begin
            found <= 1'b1;
            oldest <= slot_id[ix];
          end
          if (!act && !free_found) begin
            free_found <= 1'b1;
            free_ix <= ix;
          end
          if (act && due && (!best_found || is_older(slot_id[ix], best_id))) begin
            best_found <= 1'b1;
            best_ix <= ix;
            best_id <= slot_id[ix];
          end
          idx <= last ? '0 : idx + CW'(1);
        end
        S_APPLY: begin
          o_status <= ST_DONE;
          o_slot <= 3'd0;
          o_pid <= 32'd0;
          o_sop <= 5'd0;
          case (kind_r)
            KIND_ENQUEUE: begin
              if (free_found && (!found || (next_id - oldest) < 32'(size))) begin
                slot_active[free_ix] <= 1'b1;
                slot_id[free_ix] <= next_id;
                slot_opcode[free_ix] <= opc_r;
                slot_next_try[free_ix] <= 32'd0;
                slot_timeout[free_ix] <= first_timeout;
                slot_ack_count[free_ix] <= 8'd0;
                o_slot <= 3'(free_ix);
                o_pid <= next_id;
                next_id <= next_id + 32'd1;
              end else begin
                o_status <= ST_REFUSED;
              end
            end
            KIND_POLL: begin
              if (best_found) begin
                slot_next_try[best_ix] <= sat_add(now_r, slot_timeout[best_ix]);
                slot_timeout[best_ix] <= sat_add(slot_timeout[best_ix],
                                                 slot_timeout[best_ix]);
                slot_ack_count[best_ix] <= 8'd0;
                o_slot <= 3'(best_ix);
                o_pid <= slot_id[best_ix];
                o_sop <= slot_opcode[best_ix];
              end else begin
                o_status <= ST_NOTHING_DUE;
              end
            end
            KIND_ACK: begin
              if (act) begin
                if (slot_id[ix] == ack_r) slot_active[ix] <= 1'b0;
                else if (slot_id[ix] < ack_r && slot_ack_count[ix] != 8'hFF)
                  slot_ack_count[ix] <= slot_ack_count[ix] + 8'd1;
              end
            end
            default: begin
              if (act) begin
                slot_next_try[ix] <= now_r;
                slot_timeout[ix] <= first_timeout;
              end
            end
          endcase
          if ((kind_r == KIND_ACK || kind_r == KIND_RESCHED) && !last)
            idx <= idx + CW'(1);
          else
            idx <= '0;
          found <= 1'b0;
          wait_acc <= MAX_TICKS;
        end
        S_SCAN2: begin
          if (act) begin
            if (slot_next_try[ix] <= now_r) wait_acc <= 32'd0;
            else if (slot_next_try[ix] - now_r < wait_acc)
              wait_acc <= slot_next_try[ix] - now_r;
            if (!found || is_older(slot_id[ix], oldest)) begin
              found <= 1'b1;
              oldest <= slot_id[ix];
            end
          end
          idx <= last ? '0 : idx + CW'(1);
        end
        default: ;
      endcase
    end
  end

  logic [31:0] span;
  assign span = next_id - oldest;

  assign res.status = o_status;
  assign res.slot = o_slot;
  assign res.pkt_seq = o_pid;
  assign res.sent_opcode = o_sop;
  assign res.wait_ticks = wait_acc;
  assign res.window_empty = !found;
  always_comb begin
    if (!found) res.sequenced_free = 4'(size);
    else if (span >= 32'(size)) res.sequenced_free = 4'd0;
    else res.sequenced_free = 4'(32'(size) - span);
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !res.valid) else $error("ready while a result is pending");
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> state == S_SCAN1) else $error("scan not started");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx < size) else $error("slot index beyond window");
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    next_id != $past(next_id) |-> $past(state) == S_APPLY && $past(kind_r) == KIND_ENQUEUE)
    else $error("packet ID moved outside an enqueue");

endmodule

/* design/retransmit_window_scheduler_top.sv */
// Top level of the retransmit window scheduler.
// Commands arrive on cmd (kind, now, ack_id, opcode); each yields one result
// item on res (status, slot, pkt_seq, sent_opcode, wait_ticks, window_empty,
// sequenced_free). Registers are written through the APB port: window_size at
// 0x0, first_timeout at 0x4, ack_retransmit_threshold at 0x8.
// A command is accepted only while the block is idle. A sequencer visits one
// window slot per cycle: one pass finds the oldest ID, the first free slot and
// the oldest due slot, then a single apply step (or a pass over the slots for
// ack and schedule-now), then a pass that computes the wait time and the oldest
// remaining ID. The next command is taken the cycle after the result is taken.
// The result holds in its register while the receiver stalls, and no new
// command is taken meanwhile.
// Reset empties the window, clears the next packet ID and loads the register
// defaults (8, 2, 3).
module retransmit_window_scheduler_top
  import rws_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rws_cmd_if.sink     cmd,
  rws_res_if.source   res
);

  logic [3:0]  window_size;
  logic [31:0] first_timeout;
  logic [7:0]  ack_threshold;

  rws_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .window_size, .first_timeout, .ack_threshold
  );

  rws_engine #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_engine (
    .clk, .rst, .window_size, .first_timeout, .ack_threshold,
    .cmd(cmd), .res(res)
  );

endmodule

/* tb/retransmit_window_scheduler_top_tb.sv */
// Self-checking testbench for the retransmit window scheduler: directed table, then random phases.
`timescale 1ns / 100ps

module retransmit_window_scheduler_top_tb;
  import rws_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot;
    logic [31:0] pkt_seq;
    logic [4:0]  sent_opcode;
    logic [31:0] wait_ticks;
    logic        window_empty;
    logic [3:0]  sequenced_free;
  } sched_res_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now;
    logic [31:0] ack_id;
    logic [4:0]  opcode;
    logic        typed;
    sched_res_t  res;
  } cmd_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rws_cmd_if cmd ();
  rws_res_if res ();

  retransmit_window_scheduler_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd.sink), .res(res.source)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Mirror of the window state.
  logic [3:0]  win_size_reg;
  logic [31:0] init_timeout_reg;
  logic [7:0]  ack_thresh_reg;
  logic        win_active [8];
  logic [31:0] win_id [8];
  logic [4:0]  win_opcode [8];
  logic [31:0] win_next_try [8];
  logic [31:0] win_timeout [8];
  logic [7:0]  win_ack_count [8];
  logic [31:0] win_next_id;

  sched_res_t  pending_results[$];
  cmd_row_t    directed_rows[$];
  int          errors;
  int          items_sent;
  int          results_seen;
  int          kind_count [4];
  int          refused_count;
  int          idle_cycles;
  logic        idling_on;
  logic [31:0] tick_base;

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int active_size();
    if (win_size_reg == 4'd0) return 1;
    if (win_size_reg > 4'd8) return 8;
    return int'(win_size_reg);
  endfunction

  // Returns whether a scanned slot is active; oldest gets the oldest ID among them.
  function automatic logic oldest_active(input int sz, output logic [31:0] oldest);
    logic any;
    logic [31:0] d;
    any = 1'b0;
    oldest = '0;
    for (int i = 0; i < sz; i++) begin
      d = win_id[i] - oldest;
      if (win_active[i] && (!any || d >= 32'h8000_0000)) begin
        any = 1'b1;
        oldest = win_id[i];
      end
    end
    return any;
  endfunction

  function automatic sched_res_t schedule_step(input kind_t kind, input logic [31:0] now,
                                               input logic [31:0] ack_id,
                                               input logic [4:0] opcode);
    sched_res_t r;
    int sz;
    int best;
    logic any;
    logic placed;
    logic [31:0] oldest;
    logic [31:0] span;
    logic [31:0] d;
    sz = active_size();
    r = '0;
    r.status = ST_DONE;
    case (kind)
      KIND_ENQUEUE: begin
        placed = 1'b0;
        any = oldest_active(sz, oldest);
        if (!any || (win_next_id - oldest) < sz) begin
          for (int i = 0; i < sz; i++) begin
            if (!placed && !win_active[i]) begin
              win_active[i] = 1'b1;
              win_id[i] = win_next_id;
              win_opcode[i] = opcode;
              win_next_try[i] = '0;
              win_timeout[i] = init_timeout_reg;
              win_ack_count[i] = '0;
              r.slot = i[2:0];
              r.pkt_seq = win_next_id;
              win_next_id = win_next_id + 1;
              placed = 1'b1;
            end
          end
        end
        if (!placed) r.status = ST_REFUSED;
      end
      KIND_ACK: begin
        for (int i = 0; i < sz; i++) begin
          if (win_active[i]) begin
            if (win_id[i] == ack_id) win_active[i] = 1'b0;
            else if (win_id[i] < ack_id && win_ack_count[i] != 8'hFF)
              win_ack_count[i] = win_ack_count[i] + 1;
          end
        end
      end
      KIND_POLL: begin
        any = 1'b0;
        best = 0;
        for (int i = 0; i < sz; i++) begin
          d = win_id[i] - win_id[best];
          if (win_active[i] && (win_ack_count[i] >= ack_thresh_reg || now >= win_next_try[i])
              && (!any || d >= 32'h8000_0000)) begin
            any = 1'b1;
            best = i;
          end
        end
        if (any) begin
          win_next_try[best] = add_clamped(now, win_timeout[best]);
          win_timeout[best] = add_clamped(win_timeout[best], win_timeout[best]);
          win_ack_count[best] = '0;
          r.slot = best[2:0];
          r.pkt_seq = win_id[best];
          r.sent_opcode = win_opcode[best];
        end else begin
          r.status = ST_NOTHING_DUE;
        end
      end
      default: begin
        for (int i = 0; i < sz; i++) begin
          if (win_active[i]) begin
            win_next_try[i] = now;
            win_timeout[i] = init_timeout_reg;
          end
        end
      end
    endcase
    r.wait_ticks = 32'hFFFF_FFFF;
    for (int i = 0; i < sz; i++) begin
      if (win_active[i]) begin
        d = (win_next_try[i] <= now) ? 32'd0 : win_next_try[i] - now;
        if (d < r.wait_ticks) r.wait_ticks = d;
      end
    end
    any = oldest_active(sz, oldest);
    r.window_empty = !any;
    if (any) begin
      span = win_next_id - oldest;
      r.sequenced_free = (span >= sz) ? 4'd0 : 4'(sz - span);
    end else begin
      r.sequenced_free = 4'(sz);
    end
    return r;
  endfunction

  task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (index)
      REG_WINDOW_SIZE: win_size_reg = value[3:0];
      REG_INIT_TIMEOUT: init_timeout_reg = value;
      default: ack_thresh_reg = value[7:0];
    endcase
  endtask

  task automatic send_cmd(input cmd_row_t row);
    sched_res_t predicted;
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      cmd.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.kind = row.kind;
    cmd.now = row.now;
    cmd.ack_id = row.ack_id;
    cmd.opcode = row.opcode;
    do @(posedge clk); while (!cmd.ready);
    predicted = schedule_step(row.kind, row.now, row.ack_id, row.opcode);
    pending_results.push_back(row.typed ? row.res : predicted);
    items_sent++;
    kind_count[row.kind]++;
  endtask

  task automatic drain_window();
    @(negedge clk);
    cmd.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Leave margin after the last result before touching registers.
    repeat (40) @(posedge clk);
  endtask

  function automatic cmd_row_t random_cmd();
    cmd_row_t row;
    int pick;
    int tries;
    row = '0;
    pick = $urandom_range(0, 99);
    if (pick < 35) row.kind = KIND_ENQUEUE;
    else if (pick < 62) row.kind = KIND_ACK;
    else if (pick < 92) row.kind = KIND_POLL;
    else row.kind = KIND_RESCHED;
    tick_base = tick_base + $urandom_range(0, 6);
    case ($urandom_range(0, 19))
      0: row.now = $urandom();
      1: row.now = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: row.now = tick_base;
    endcase
    row.opcode = 5'($urandom_range(0, 31));
    row.ack_id = $urandom();
    if (row.kind == KIND_ACK) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Mostly acknowledge a packet that is really in flight.
        for (tries = 0; tries < 16; tries++) begin
          pick = $urandom_range(0, 7);
          if (win_active[pick]) begin
            row.ack_id = win_id[pick];
            break;
          end
        end
      end else if (pick < 85) begin
        row.ack_id = win_next_id + $urandom_range(0, 3);
      end
    end
    return row;
  endfunction

  task automatic add_row(input kind_t kind, input logic [31:0] now, input logic [31:0] ack_id,
                         input logic [4:0] opcode, input logic typed, input sched_res_t r);
    cmd_row_t row;
    row.kind = kind;
    row.now = now;
    row.ack_id = ack_id;
    row.opcode = opcode;
    row.typed = typed;
    row.res = r;
    directed_rows.push_back(row);
  endtask

  // Result sink with bursts of backpressure.
  int stall_left;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_res_t exp_r;
    if (!rst && res.valid && res.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no command outstanding", $time);
      end else begin
        exp_r = pending_results.pop_front();
        if (res.status == ST_REFUSED) refused_count++;
        if (res.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, res.status);
        if (res.slot !== exp_r.slot)
          $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, res.slot);
        if (res.pkt_seq !== exp_r.pkt_seq)
          $display("%0t: pkt_seq expected %h actual %h", $time, exp_r.pkt_seq,
                   res.pkt_seq);
        if (res.sent_opcode !== exp_r.sent_opcode)
          $display("%0t: sent_opcode expected %0d actual %0d", $time, exp_r.sent_opcode,
                   res.sent_opcode);
        if (res.wait_ticks !== exp_r.wait_ticks)
          $display("%0t: wait_ticks expected %h actual %h", $time, exp_r.wait_ticks,
                   res.wait_ticks);
        if (res.window_empty !== exp_r.window_empty)
          $display("%0t: window_empty expected %0b actual %0b", $time, exp_r.window_empty,
                   res.window_empty);
        if (res.sequenced_free !== exp_r.sequenced_free)
          $display("%0t: sequenced_free expected %0d actual %0d", $time,
                   exp_r.sequenced_free, res.sequenced_free);
        if (res.status !== exp_r.status || res.slot !== exp_r.slot
            || res.pkt_seq !== exp_r.pkt_seq || res.sent_opcode !== exp_r.sent_opcode
            || res.wait_ticks !== exp_r.wait_ticks || res.window_empty !== exp_r.window_empty
            || res.sequenced_free !== exp_r.sequenced_free)
          errors++;
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sched_res_t r;
    cmd_row_t row;
    logic [3:0]  phase_size [7];
    logic [31:0] phase_timeout [7];
    logic [7:0]  phase_thresh [7];
    phase_size = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8};
    phase_timeout = '{32'd1, 32'hFFFF_FFFF, 32'd5, 32'd7, 32'd3, 32'hFFFF_0000, 32'd2};
    phase_thresh = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd4, 8'd1, 8'd3};
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    refused_count = 0;
    kind_count = '{0, 0, 0, 0};
    idle_cycles = 0;
    stall_left = 0;
    idling_on = 1'b1;
    tick_base = '0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd.valid = 1'b0;
    cmd.kind = KIND_ENQUEUE;
    cmd.now = '0;
    cmd.ack_id = '0;
    cmd.opcode = '0;
    res.ready = 1'b1;
    win_size_reg = WSIZE_RESET;
    init_timeout_reg = ITIMEOUT_RESET;
    ack_thresh_reg = THRESH_RESET;
    win_next_id = '0;
    for (int i = 0; i < 8; i++) begin
      win_active[i] = 1'b0;
      win_id[i] = '0;
      win_opcode[i] = '0;
      win_next_try[i] = '0;
      win_timeout[i] = '0;
      win_ack_count[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty window right after reset: nothing to send.
    r = '{ST_NOTHING_DUE, 3'd0, 32'd0, 5'd0, 32'hFFFF_FFFF, 1'b1, 4'd8};
    add_row(KIND_POLL, 32'd0, 32'd0, 5'd0, 1'b1, r);
    r = '{ST_DONE, 3'd0, 32'd0, 5'd0, 32'd0, 1'b0, 4'd7};
    add_row(KIND_ENQUEUE, 32'd0, 32'd0, 5'd31, 1'b1, r);
    r = '{ST_DONE, 3'd1, 32'd1, 5'd0, 32'd0, 1'b0, 4'd6};
    add_row(KIND_ENQUEUE, 32'd0, 32'd0, 5'd0, 1'b1, r);
    r = '{ST_DONE, 3'd0, 32'd0, 5'd31, 32'd0, 1'b0, 4'd6};
    add_row(KIND_POLL, 32'd5, 32'd0, 5'd0, 1'b1, r);
    r = '0;
    // Fill the window until an enqueue is refused.
    for (int i = 0; i < 7; i++) add_row(KIND_ENQUEUE, 32'd6, 32'd0, 5'(i * 5 + 1), 1'b0, r);
    // Later-ID acks push the older slots to early retransmit.
    add_row(KIND_ACK, 32'd6, 32'd3, 5'd0, 1'b0, r);
    add_row(KIND_ACK, 32'd6, 32'hFFFF_FFFF, 5'd0, 1'b0, r);
    add_row(KIND_ACK, 32'd6, 32'd3, 5'd0, 1'b0, r);
    add_row(KIND_POLL, 32'd0, 32'd0, 5'd0, 1'b0, r);
    add_row(KIND_ACK, 32'd6, 32'd0, 5'd0, 1'b0, r);
    add_row(KIND_RESCHED, 32'hFFFF_FFFF, 32'd0, 5'd0, 1'b0, r);
    add_row(KIND_POLL, 32'hFFFF_FFFF, 32'd0, 5'd0, 1'b0, r);
    add_row(KIND_POLL, 32'hFFFF_FFFE, 32'd0, 5'd0, 1'b0, r);
    add_row(KIND_ENQUEUE, 32'd7, 32'd0, 5'd31, 1'b0, r);
    add_row(KIND_RESCHED, 32'd0, 32'd0, 5'd0, 1'b0, r);
    add_row(KIND_POLL, 32'd0, 32'd0, 5'd0, 1'b0, r);
    foreach (directed_rows[i]) send_cmd(directed_rows[i]);
    tick_base = 32'd10;

    for (int p = 0; p < 7; p++) begin
      drain_window();
      apb_write(REG_WINDOW_SIZE, {28'd0, phase_size[p]});
      apb_write(REG_INIT_TIMEOUT, phase_timeout[p]);
      apb_write(REG_ACK_THRESH, {24'd0, phase_thresh[p]});
      for (int n = 0; n < 162; n++) begin
        // Back-to-back traffic at the tail of the run.
        if (p == 6 && n >= 80) idling_on = 1'b0;
        row = random_cmd();
        send_cmd(row);
      end
    end

    @(negedge clk);
    cmd.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d commands (enqueue %0d, ack %0d, poll %0d, reschedule %0d);",
             items_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("checked %0d results, %0d refused enqueues, 7 register settings.",
             results_seen, refused_count);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
